/* design/cnv_pkg.sv */
package cnv_pkg;

  // Field and arithmetic widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned KSIZE     = 3;
  localparam int unsigned COEF_FRAC = 12;
  localparam int unsigned CNT_X_W   = 11;
  localparam int unsigned CNT_Y_W   = 12;
  localparam int unsigned ROW_W     = KSIZE * COEF_W;
  localparam int unsigned PROD_W    = PIX_W + 1 + COEF_W;
  localparam int unsigned PART_W    = PROD_W + 2;
  localparam int unsigned SUM_W     = PART_W + 2;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register reset values
  localparam logic [CNT_X_W-1:0] WIDTH_RST    = 11'd1024;
  localparam logic [CNT_Y_W-1:0] HEIGHT_RST   = 12'd1;
  localparam logic [ROW_W-1:0]   COEF_TOP_RST = 48'h0000_0000_0000;
  localparam logic [ROW_W-1:0]   COEF_MID_RST = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0]   COEF_BOT_RST = 48'h0000_0000_0000;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_COEF_TOP = 3'd2,
    REG_COEF_MID = 3'd3,
    REG_COEF_BOT = 3'd4
  } reg_idx_e;

  // One window column, row 0 (top) at index 0
  typedef logic [KSIZE-1:0][PIX_W-1:0]  pix_col_t;
  // Coefficients that meet one window column, row 0 at index 0
  typedef logic [KSIZE-1:0][COEF_W-1:0] coef_col_t;

  // Control of one window cell
  typedef struct packed {
    logic shift;    // load the column from the right-hand neighbor
    logic clr;      // load zero instead (left padding at row start)
    logic advance;  // pipeline moves: register the partial sum
  } cell_ctl_t;

endpackage

/* design/conv2d_3x3_zero_padded.sv */
// 3x3 convolution over a zero-padded 8-bit grayscale stream.
// Input channel (in_valid_i / in_stall_o / pixel_i): one item per scan position in
// raster order, (width+1)*(height+1) items per frame; the extra column and row
// carry padding and their pixel is ignored. An item at x>=1, y>=1 gives output
// pixel (x-1, y-1) on the output channel (out_valid_o / out_stall_i), flagged
// with end_of_row_o on the last pixel of a row and last_of_frame_o on the last
// pixel of the frame. Other items give no result.
// Stages: item and line buffer reads, window, partial sums, then the output register.
// Throughput: one item per cycle while in_stall_o is low; the window cell chain
// advances once per item, each line buffer read and written once per item with x < width.
// Receiver stall: the output register and a one-entry skid buffer keep items
// flowing; in_stall_o rises only when the skid buffer fills, in the cycle after a
// result meets a stalled, full output register, and falls once it drains.
// Configuration (cfg_*) is always ready; write it only while the block is idle.
// Reset clears counters, window and pipeline valid bits and loads the default
// registers (width 1024, height 1, identity kernel). Line buffers are not
// cleared; every entry is written on the first row before it is read.
module conv2d_3x3_zero_padded #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cnv_pkg::PIX_W-1:0]          pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cnv_pkg::PIX_W-1:0]          out_pixel_o,
  output logic                               end_of_row_o,
  output logic                               last_of_frame_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cnv_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [cnv_pkg::ROW_W-1:0]          cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam logic [cnv_pkg::CNT_X_W-1:0] WidthCap =
      (MAX_WIDTH >= (1 << cnv_pkg::CNT_X_W)) ? {cnv_pkg::CNT_X_W{1'b1}}
                                             : cnv_pkg::CNT_X_W'(MAX_WIDTH);

  typedef struct packed {
    logic in_img;   // x < width
    logic y_ge1;
    logic y_ge2;
    logic y_lt_h;
    logic clr;      // x == 0
    logic emit;     // item gives a result
    logic eor;
    logic lof;
  } pos_flags_t;

  // Configuration registers
  logic [cnv_pkg::CNT_X_W-1:0] width_q;
  logic [cnv_pkg::CNT_Y_W-1:0] height_q;
  logic [cnv_pkg::ROW_W-1:0]   coef_top_q, coef_mid_q, coef_bot_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= cnv_pkg::WIDTH_RST;
      height_q   <= cnv_pkg::HEIGHT_RST;
      coef_top_q <= cnv_pkg::COEF_TOP_RST;
      coef_mid_q <= cnv_pkg::COEF_MID_RST;
      coef_bot_q <= cnv_pkg::COEF_BOT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cnv_pkg::REG_WIDTH:    width_q    <= cfg_data_i[cnv_pkg::CNT_X_W-1:0];
        cnv_pkg::REG_HEIGHT:   height_q   <= cfg_data_i[cnv_pkg::CNT_Y_W-1:0];
        cnv_pkg::REG_COEF_TOP: coef_top_q <= cfg_data_i;
        cnv_pkg::REG_COEF_MID: coef_mid_q <= cfg_data_i;
        cnv_pkg::REG_COEF_BOT: coef_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline enable: everything moves unless the skid buffer is full
  logic skid_full_q;
  logic en, accept;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;
  assign accept     = in_valid_i && en;

  // Effective frame size and scan position
  logic [cnv_pkg::CNT_X_W-1:0] w_eff, col_q, x_cur;
  logic [cnv_pkg::CNT_Y_W-1:0] h_eff, row_q, y_cur;
  pos_flags_t                  flags_d;

  always_comb begin
    priority if (width_q == '0) begin
      w_eff = cnv_pkg::CNT_X_W'(1);
    end else if (width_q > WidthCap) begin
      w_eff = WidthCap;
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? cnv_pkg::CNT_Y_W'(1) : height_q;
    x_cur = (col_q > w_eff) ? '0 : col_q;
    y_cur = (row_q > h_eff) ? '0 : row_q;

    flags_d.in_img = x_cur < w_eff;
    flags_d.y_ge1  = y_cur != '0;
    flags_d.y_ge2  = y_cur > cnv_pkg::CNT_Y_W'(1);
    flags_d.y_lt_h = y_cur < h_eff;
    flags_d.clr    = x_cur == '0;
    flags_d.emit   = (x_cur != '0) && (y_cur != '0);
    flags_d.eor    = x_cur == w_eff;
    flags_d.lof    = (x_cur == w_eff) && (y_cur == h_eff);
  end

  // Scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (x_cur >= w_eff) begin
        col_q <= '0;
        row_q <= (y_cur >= h_eff) ? '0 : y_cur + cnv_pkg::CNT_Y_W'(1);
      end else begin
        col_q <= x_cur + cnv_pkg::CNT_X_W'(1);
      end
    end
  end

  // Stage 1: item with its line buffer reads
  logic                         s1_valid_q;
  logic [cnv_pkg::PIX_W-1:0]    s1_pix_q;
  logic [AddrW-1:0]             s1_addr_q;
  pos_flags_t                   s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_addr_q  <= AddrW'(x_cur);
      s1_flags_q <= flags_d;
    end
  end

  // Line buffers
  logic [cnv_pkg::PIX_W-1:0] above_rd, two_rd;
  logic [cnv_pkg::PIX_W-1:0] top_px, mid_px, bot_px;
  logic                      lb_we, lb_re;

  assign lb_re = accept && flags_d.in_img;
  assign lb_we = en && s1_valid_q && s1_flags_q.in_img;

  assign top_px = (s1_flags_q.in_img && s1_flags_q.y_ge2)  ? two_rd   : '0;
  assign mid_px = (s1_flags_q.in_img && s1_flags_q.y_ge1)  ? above_rd : '0;
  assign bot_px = (s1_flags_q.in_img && s1_flags_q.y_lt_h) ? s1_pix_q : '0;

  cnv_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_above (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (s1_addr_q),
    .wdata_i (bot_px),
    .re_i    (lb_re),
    .raddr_i (AddrW'(x_cur)),
    .rdata_o (above_rd)
  );

  cnv_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_two_above (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (s1_addr_q),
    .wdata_i (above_rd),
    .re_i    (lb_re),
    .raddr_i (AddrW'(x_cur)),
    .rdata_o (two_rd)
  );

  // Window: chain of column cells, new column enters at the right
  cnv_pkg::pix_col_t                  new_col;
  cnv_pkg::pix_col_t                  cell_col [cnv_pkg::KSIZE];
  cnv_pkg::coef_col_t                 cell_coef [cnv_pkg::KSIZE];
  cnv_pkg::cell_ctl_t                 cell_ctl [cnv_pkg::KSIZE];
  logic signed [cnv_pkg::PART_W-1:0]  part [cnv_pkg::KSIZE];
  logic [cnv_pkg::ROW_W-1:0]          coef_rows [cnv_pkg::KSIZE];

  assign new_col[0]   = top_px;
  assign new_col[1]   = mid_px;
  assign new_col[2]   = bot_px;
  assign coef_rows[0] = coef_top_q;
  assign coef_rows[1] = coef_mid_q;
  assign coef_rows[2] = coef_bot_q;

  for (genvar l = 0; l < cnv_pkg::KSIZE; l++) begin : g_cell
    cnv_pkg::pix_col_t col_in;

    // Flipped kernel: window (k, l) meets kernel (2-k, 2-l)
    for (genvar k = 0; k < cnv_pkg::KSIZE; k++) begin : g_coef
      assign cell_coef[l][k] =
          coef_rows[cnv_pkg::KSIZE-1-k][cnv_pkg::COEF_W*(cnv_pkg::KSIZE-1-l) +: cnv_pkg::COEF_W];
    end

    if (l == cnv_pkg::KSIZE - 1) begin : g_right
      assign col_in = new_col;
    end else begin : g_inner
      assign col_in = cell_col[l+1];
    end

    assign cell_ctl[l].shift   = en && s1_valid_q;
    assign cell_ctl[l].clr     = (l != cnv_pkg::KSIZE - 1) && s1_flags_q.clr;
    assign cell_ctl[l].advance = en;

    cnv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[l]),
      .col_i  (col_in),
      .coef_i (cell_coef[l]),
      .col_o  (cell_col[l]),
      .part_o (part[l])
    );
  end

  // Result tags alongside the window (stage 2) and partial sums (stage 3)
  logic s2_valid_q, s2_eor_q, s2_lof_q;
  logic s3_valid_q, s3_eor_q, s3_lof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_flags_q.emit;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_eor_q <= s1_flags_q.eor;
      s2_lof_q <= s1_flags_q.lof;
      s3_eor_q <= s2_eor_q;
      s3_lof_q <= s2_lof_q;
    end
  end

  // Final sum, scale and clamp
  logic signed [cnv_pkg::SUM_W-1:0] sum;
  logic [cnv_pkg::PIX_W-1:0]        res_pix;

  always_comb begin
    sum = cnv_pkg::SUM_W'(part[0]) + cnv_pkg::SUM_W'(part[1]) + cnv_pkg::SUM_W'(part[2]);
    priority if (sum[cnv_pkg::SUM_W-1]) begin
      res_pix = '0;
    end else if (sum[cnv_pkg::SUM_W-2:cnv_pkg::COEF_FRAC+cnv_pkg::PIX_W] != '0) begin
      res_pix = cnv_pkg::PIX_MAX;
    end else begin
      res_pix = sum[cnv_pkg::COEF_FRAC +: cnv_pkg::PIX_W];
    end
  end

  // Output register with one-entry skid buffer
  logic                      out_valid_q, out_eor_q, out_lof_q;
  logic [cnv_pkg::PIX_W-1:0] out_pix_q, skid_pix_q;
  logic                      skid_eor_q, skid_lof_q;
  logic                      out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
      out_pix_q   <= '0;
      out_eor_q   <= 1'b0;
      out_lof_q   <= 1'b0;
      skid_pix_q  <= '0;
      skid_eor_q  <= 1'b0;
      skid_lof_q  <= 1'b0;
    end else if (skid_full_q) begin
      if (out_take) begin
        out_pix_q   <= skid_pix_q;
        out_eor_q   <= skid_eor_q;
        out_lof_q   <= skid_lof_q;
        skid_full_q <= 1'b0;
      end
    end else if (s3_valid_q) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
        out_pix_q   <= res_pix;
        out_eor_q   <= s3_eor_q;
        out_lof_q   <= s3_lof_q;
      end else begin
        skid_full_q <= 1'b1;
        skid_pix_q  <= res_pix;
        skid_eor_q  <= s3_eor_q;
        skid_lof_q  <= s3_lof_q;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pix_q;
  assign end_of_row_o    = out_eor_q;
  assign last_of_frame_o = out_lof_q;

endmodule

/* design/cnv_line_buf.sv */
module cnv_line_buf #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [cnv_pkg::PIX_W-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [cnv_pkg::PIX_W-1:0]     rdata_o
);

  logic [cnv_pkg::PIX_W-1:0] mem_q [Depth];
  logic [cnv_pkg::PIX_W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cnv_cell.sv */
module cnv_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cnv_pkg::cell_ctl_t                  ctl_i,
  input  cnv_pkg::pix_col_t                   col_i,
  input  cnv_pkg::coef_col_t                  coef_i,
  output cnv_pkg::pix_col_t                   col_o,
  output logic signed [cnv_pkg::PART_W-1:0]   part_o
);

  cnv_pkg::pix_col_t                  col_q;
  logic signed [cnv_pkg::PART_W-1:0]  part_q, part_d;

  // Column of the window: three products and their sum
  always_comb begin
    logic signed [cnv_pkg::PROD_W-1:0] prod;
    part_d = '0;
    for (int k = 0; k < cnv_pkg::KSIZE; k++) begin
      prod   = $signed({1'b0, col_q[k]}) * $signed(coef_i[k]);
      part_d = part_d + cnv_pkg::PART_W'(prod);
    end
  end

  // Window column, handed on to the left neighbor on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctl_i.shift) begin
      col_q <= ctl_i.clr ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      part_q <= part_d;
    end
  end

  assign col_o  = col_q;
  assign part_o = part_q;

endmodule

/* design/cnv_checker.sv */
module cnv_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [cnv_pkg::PIX_W-1:0]      out_pixel_o,
  input logic                           end_of_row_o,
  input logic                           last_of_frame_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pixel_o) &&
      $stable(end_of_row_o) && $stable(last_of_frame_o))
    else $error("stalled output item changed");

  // The last pixel of a frame also ends its row
  a_lof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && last_of_frame_o |-> end_of_row_o)
    else $error("last_of_frame without end_of_row");

  // Input stall only follows a stalled output item
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // Input stall never outlasts a free output: the skid buffer drains into it
  a_stall_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !$past(out_stall_i) |-> !in_stall_o)
    else $error("input still stalled after output was free");

endmodule

bind conv2d_3x3_zero_padded cnv_checker u_cnv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_pixel_o     (out_pixel_o),
  .end_of_row_o    (end_of_row_o),
  .last_of_frame_o (last_of_frame_o)
);

/* bench/conv2d_checker.sv */
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the 3x3 convolver,
// keeps its own copy of the scan state and the kernel, and compares every
// accepted result item with the oldest expected one.
module conv2d_checker
  import cnv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PIX_W-1:0]     out_pixel_i,
  input  logic                 end_of_row_i,
  input  logic                 last_of_frame_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [ROW_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             lof;
  } out_item_t;

  out_item_t          expected_pixels[$];
  out_item_t          want;

  logic [CNT_X_W-1:0] width_q;
  logic [CNT_Y_W-1:0] height_q;
  logic [ROW_W-1:0]   coef_q [KSIZE];
  logic [PIX_W-1:0]   line_above [MAX_WIDTH];
  logic [PIX_W-1:0]   line_two_above [MAX_WIDTH];
  logic [PIX_W-1:0]   win [KSIZE][KSIZE];
  int unsigned        col;
  int unsigned        row;

  assign pending_o = expected_pixels.size();

  // Signed Q4.12 coefficient at kernel row r, column c
  function automatic int kernel_coef(int unsigned r, int unsigned c);
    return $signed(coef_q[r][c*COEF_W +: COEF_W]);
  endfunction

  // Advance the scan by one position and queue the output pixel it completes, if any
  task automatic convolve_item(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      x;
    int unsigned      y;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    longint           sum;
    longint           q;
    out_item_t        res;

    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_q;
    if (h == 0) h = 1;
    // counters left past the frame by a register change start over
    if (col > w) col = 0;
    if (row > h) row = 0;
    x = col;
    y = row;

    // left padding columns
    if (x == 0) begin
      foreach (win[k, l]) win[k][l] = '0;
    end

    top = '0;
    mid = '0;
    bot = '0;
    if (x < w) begin
      if (y >= 2) top = line_two_above[x];
      if (y >= 1) mid = line_above[x];
      if (y < h) bot = pix;
      line_two_above[x] = line_above[x];
      line_above[x] = bot;
    end

    for (int k = 0; k < KSIZE; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;

    if (x >= 1 && y >= 1) begin
      sum = 0;
      // flipped kernel: true convolution
      for (int k = 0; k < KSIZE; k++) begin
        for (int l = 0; l < KSIZE; l++) begin
          sum += longint'(kernel_coef(KSIZE - 1 - k, KSIZE - 1 - l)) * longint'(win[k][l]);
        end
      end
      if (sum < 0) begin
        res.pix = '0;
      end else begin
        q = sum >>> COEF_FRAC;
        res.pix = (q > PIX_MAX) ? PIX_MAX : q[PIX_W-1:0];
      end
      res.eor = (x == w);
      res.lof = (x == w) && (y == h);
      expected_pixels.push_back(res);
    end

    if (x >= w) begin
      col = 0;
      row = (y >= h) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = WIDTH_RST;
      height_q = HEIGHT_RST;
      coef_q[0] = COEF_TOP_RST;
      coef_q[1] = COEF_MID_RST;
      coef_q[2] = COEF_BOT_RST;
      foreach (line_above[i]) line_above[i] = '0;
      foreach (line_two_above[i]) line_two_above[i] = '0;
      foreach (win[k, l]) win[k][l] = '0;
      col = 0;
      row = 0;
      expected_pixels.delete();
      fail_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WIDTH:    width_q = cfg_data_i[CNT_X_W-1:0];
          REG_HEIGHT:   height_q = cfg_data_i[CNT_Y_W-1:0];
          REG_COEF_TOP: coef_q[0] = cfg_data_i;
          REG_COEF_MID: coef_q[1] = cfg_data_i;
          REG_COEF_BOT: coef_q[2] = cfg_data_i;
          default: ;
        endcase
      end

      // results first: an item accepted on this edge cannot be out yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("out_pixel: no item expected, actual %0d", out_pixel_i);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_i !== want.pix) begin
            $error("out_pixel: expected %0d, actual %0d", want.pix, out_pixel_i);
            fail_count_o++;
          end
          if (end_of_row_i !== want.eor) begin
            $error("end_of_row: expected %0d, actual %0d", want.eor, end_of_row_i);
            fail_count_o++;
          end
          if (last_of_frame_i !== want.lof) begin
            $error("last_of_frame: expected %0d, actual %0d", want.lof, last_of_frame_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) convolve_item(pixel_i);
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cnv_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned Q_ONE        = 1 << COEF_FRAC;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SLOW_SRC,
    PACE_SLOW_SINK,
    PACE_BOTH
  } pace_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic                 end_of_row;
  logic                 last_of_frame;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   pending;

  int unsigned          idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          quiet_cycles = 0;

  // scan position and frame size as the block sees them
  logic [CNT_X_W-1:0]   width_reg = WIDTH_RST;
  logic [CNT_Y_W-1:0]   height_reg = HEIGHT_RST;
  int unsigned          scan_col = 0;
  int unsigned          scan_row = 0;
  int unsigned          random_items = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  conv2d_3x3_zero_padded #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_pixel_o    (out_pixel),
    .end_of_row_o   (end_of_row),
    .last_of_frame_o(last_of_frame),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  conv2d_checker #(
    .MAX_WIDTH(MAX_W)
  ) conv_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .pixel_i        (pixel),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_pixel_i    (out_pixel),
    .end_of_row_i   (end_of_row),
    .last_of_frame_i(last_of_frame),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver stall
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles in a row with no item moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // counters past the frame restart, as in the block
  function automatic void sync_scan();
    if (scan_col > eff_width()) scan_col = 0;
    if (scan_row > eff_height()) scan_row = 0;
  endfunction

  // positions left up to and including the frame's last one
  function automatic int unsigned frame_left();
    sync_scan();
    return (eff_height() - scan_row) * (eff_width() + 1) + eff_width() - scan_col + 1;
  endfunction

  // value in the low bits, random junk above
  function automatic logic [ROW_W-1:0] pad_junk(int unsigned v, int unsigned bits);
    logic [ROW_W-1:0] d;
    d = {$urandom, $urandom};
    d = (d & ~((48'd1 << bits) - 48'd1)) | ROW_W'(v);
    return d;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // one kernel row: small signed, full random, extremes or small positive
  function automatic logic [ROW_W-1:0] rand_coef_row();
    logic [ROW_W-1:0] r;
    int unsigned      style;
    style = $urandom_range(3);
    r = {$urandom, $urandom};
    for (int c = 0; c < KSIZE; c++) begin
      case (style)
        0: r[c*COEF_W +: COEF_W] = COEF_W'($urandom_range(2 * Q_ONE) - Q_ONE);
        1: ;
        2: begin
          case ($urandom_range(3))
            0:       r[c*COEF_W +: COEF_W] = 16'h7FFF;
            1:       r[c*COEF_W +: COEF_W] = 16'h8000;
            2:       r[c*COEF_W +: COEF_W] = 16'hFFFF;
            default: r[c*COEF_W +: COEF_W] = '0;
          endcase
        end
        default: r[c*COEF_W +: COEF_W] = COEF_W'($urandom_range(Q_ONE / 2));
      endcase
    end
    return r;
  endfunction

  task automatic set_pace();
    pace_e p;
    p = pace_e'($urandom_range(3));
    case (p)
      PACE_FULL:      begin idle_pct = 0;  stall_pct = 0;  end
      PACE_SLOW_SRC:  begin idle_pct = 88; stall_pct = 0;  end
      PACE_SLOW_SINK: begin idle_pct = 0;  stall_pct = 88; end
      default:        begin idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk_i); while (in_stall);
    sync_scan();
    if (scan_col >= eff_width()) begin
      scan_col = 0;
      scan_row = (scan_row >= eff_height()) ? 0 : scan_row + 1;
    end else begin
      scan_col++;
    end
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) push_pixel(rand_pixel());
  endtask

  // all results out, then room for items that give none
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  width_reg = data[CNT_X_W-1:0];
      REG_HEIGHT: height_reg = data[CNT_Y_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [ROW_W-1:0] k_top, input logic [ROW_W-1:0] k_mid,
                           input logic [ROW_W-1:0] k_bot);
    write_reg(REG_WIDTH, pad_junk(w, CNT_X_W));
    write_reg(REG_HEIGHT, pad_junk(h, CNT_Y_W));
    write_reg(REG_COEF_TOP, k_top);
    write_reg(REG_COEF_MID, k_mid);
    write_reg(REG_COEF_BOT, k_bot);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    int unsigned new_w;
    int unsigned new_h;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full frame at reset settings: 1024 wide, one row, identity kernel
    set_pace();
    send_pixels(frame_left());
    wait_idle();

    // single-pixel image with identity kernel
    configure(1, 1, COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST);
    push_pixel(PIX_MAX);
    send_pixels(3);
    wait_idle();

    // zero sizes act as one; largest positive kernel saturates
    configure(0, 0, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    push_pixel(PIX_MAX);
    send_pixels(3);
    wait_idle();

    // most negative kernel clamps to zero
    configure(0, 0, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    push_pixel(PIX_MAX);
    send_pixels(3);
    wait_idle();

    // small image, mixed kernel
    configure(3, 2, {16'h7FFF, 16'h8000, 16'hFFFF}, {16'hF000, 16'h0800, 16'h1000},
              {16'h0100, 16'h0200, 16'hFF00});
    send_pixels(frame_left());
    wait_idle();

    // largest sizes: width above the maximum acts as the maximum, tallest frame
    set_pace();
    configure(2047, 1, COEF_TOP_RST, COEF_MID_RST, rand_coef_row());
    send_pixels(frame_left());
    wait_idle();
    set_pace();
    configure(1, 4095, rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_pixels(frame_left());

    // random frames, some cut short and resized in mid-frame
    while (random_items < RANDOM_ITEMS) begin
      set_pace();
      if ($urandom_range(1) != 0) begin
        wait_idle();
        sync_scan();
        if ($urandom_range(2) != 0) begin
          // a wider row may only start with a new frame: the line buffers hold less
          if (scan_col == 0 && scan_row == 0) begin
            case ($urandom_range(19))
              0:          new_w = 0;
              1, 2, 3, 4: new_w = $urandom_range(9, 24);
              default:    new_w = $urandom_range(1, 8);
            endcase
          end else begin
            new_w = $urandom_range(eff_width());
          end
          write_reg(REG_WIDTH, pad_junk(new_w, CNT_X_W));
        end
        if ($urandom_range(2) != 0) begin
          case ($urandom_range(9))
            0:       new_h = 0;
            1:       new_h = $urandom_range(6, 10);
            default: new_h = $urandom_range(1, 5);
          endcase
          write_reg(REG_HEIGHT, pad_junk(new_h, CNT_Y_W));
        end
        for (int r = 0; r < KSIZE; r++) begin
          if ($urandom_range(2) == 0) write_reg(REG_COEF_TOP + r, rand_coef_row());
        end
        // unused register indexes are ignored
        if ($urandom_range(9) == 0) begin
          write_reg($urandom_range(REG_COEF_BOT + 1, (1 << REG_IDX_W) - 1), {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
      end
      n = frame_left();
      if (n > 1 && $urandom_range(4) == 0) n = $urandom_range(1, n - 1);
      send_pixels(n);
      random_items += n;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
